// ===== hdl/pip_pkg.sv =====
package pip_pkg;

  // Fixed field widths of the item and the configuration register.
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CFG_W = 7;

  // Smallest polygon that the count register is clamped to.
  localparam int unsigned MIN_VERTICES = 3;

  // Operation codes carried by an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic vtx_wr;   // write the item's point into the vertex store
    logic start;    // capture the query point and clear the flag
    logic rd_en;    // read one vertex from the store
    logic edge_ok;  // the vertex read closes an edge with the previous one
    logic last;     // the vertex read is the final one of the walk
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic done;     // the final edge has left the pipeline
    logic in_poly;  // running even-odd flag
  } dp_status_t;

endpackage

// ===== hdl/pip_dpath.sv =====
module pip_dpath #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 24,
  parameter int unsigned AW           = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pip_pkg::dp_cmd_t              cmd_i,
  input  logic [AW-1:0]                 rd_addr_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic signed [COORD_BITS-1:0]  coord_x_i,
  input  logic signed [COORD_BITS-1:0]  coord_y_i,
  output pip_pkg::dp_status_t           status_o
);
  import pip_pkg::*;

  // Differences carry one extra bit, products twice that.
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  // Vertex store, one read port and one write port.
  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;

  // Query point and the previous vertex of the walk.
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;

  // Pipeline control.
  logic r_vld_q, r_edge_q, r_last_q;
  logic d_vld_q, d_last_q;
  logic p_vld_q, p_last_q;
  logic inside_q, done_q;

  // Pipeline payload.
  logic signed [DW-1:0] a_d, b_d, c_d, e_d;
  logic signed [DW-1:0] a_q, b_q, c_q, e_q;
  logic                 dneg_q, pneg_q;
  logic signed [PW-1:0] ab_d, ce_d, ab_q, ce_q;
  logic                 straddle;
  logic                 toggle;

  always_ff @(posedge clk_i) begin
    if (cmd_i.vtx_wr) begin
      mem_x[wr_addr_i] <= coord_x_i;
      mem_y[wr_addr_i] <= coord_y_i;
    end
    if (cmd_i.rd_en) begin
      rd_x_q <= mem_x[rd_addr_i];
      rd_y_q <= mem_y[rd_addr_i];
    end
  end

  // Edge from the vertex just read (i) to the previous one (j): does it
  // straddle the query line, and the terms of the cross-multiplication.
  always_comb begin
    straddle = (rd_y_q > py_q) != (prev_y_q > py_q);
    a_d = DW'(px_q) - DW'(rd_x_q);
    b_d = DW'(prev_y_q) - DW'(rd_y_q);
    c_d = DW'(prev_x_q) - DW'(rd_x_q);
    e_d = DW'(py_q) - DW'(rd_y_q);
  end

  // Both products of the crossing test.
  always_comb begin
    ab_d = PW'(a_q) * PW'(b_q);
    ce_d = PW'(c_q) * PW'(e_q);
  end

  // The comparison flips when the edge runs downward.
  assign toggle = pneg_q ? (ab_q > ce_q) : (ab_q < ce_q);

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    if (r_vld_q) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
    end
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    e_q    <= e_d;
    dneg_q <= b_d[DW-1];
    ab_q   <= ab_d;
    ce_q   <= ce_d;
    pneg_q <= dneg_q;
  end

  // Stage valids, the running flag and the done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q  <= 1'b0;
      r_edge_q <= 1'b0;
      r_last_q <= 1'b0;
      d_vld_q  <= 1'b0;
      d_last_q <= 1'b0;
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      inside_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      r_vld_q  <= cmd_i.rd_en;
      r_edge_q <= cmd_i.edge_ok;
      r_last_q <= cmd_i.last;
      d_vld_q  <= r_vld_q & r_edge_q & straddle;
      d_last_q <= r_vld_q & r_last_q;
      p_vld_q  <= d_vld_q;
      p_last_q <= d_last_q;
      done_q   <= p_last_q;
      if (cmd_i.start) begin
        inside_q <= 1'b0;
      end else if (p_vld_q) begin
        inside_q <= inside_q ^ toggle;
      end
    end
  end

  assign status_o.done    = done_q;
  assign status_o.in_poly = inside_q;

endmodule

// ===== hdl/pip_ctrl.sv =====
module pip_ctrl #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned AW           = 6,
  parameter int unsigned NW           = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [pip_pkg::IDX_W-1:0]   vertex_index_i,
  input  logic                        cfg_we_i,
  input  logic [pip_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        inside_res_o,
  output pip_pkg::dp_cmd_t            cmd_o,
  output logic [AW-1:0]               rd_addr_o,
  output logic [AW-1:0]               wr_addr_o,
  input  pip_pkg::dp_status_t         status_i
);
  import pip_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_HOLD
  } state_e;

  state_e        state_q;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] cnt_q;
  logic [NW-1:0] n_m1, addr_full;
  logic          out_valid_q, out_inside_q;
  logic          accept, idx_ok, out_free;
  logic [31:0]   cfg_wide;
  logic [15:0]   idx_wide;

  // Clamp the written count into the supported range.
  always_comb begin
    cfg_wide = 32'(cfg_wdata_i);
    if (cfg_wide < MIN_VERTICES) begin
      n_d = NW'(MIN_VERTICES);
    end else if (cfg_wide > MAX_VERTICES) begin
      n_d = NW'(MAX_VERTICES);
    end else begin
      n_d = NW'(cfg_wide);
    end
  end

  // Items are taken only between queries.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign idx_wide   = 16'(vertex_index_i);
  assign idx_ok     = (32'(vertex_index_i) < MAX_VERTICES);
  assign wr_addr_o  = idx_wide[AW-1:0];

  // The walk reads vertex n-1 first, then 0 through n-1.
  assign n_m1      = n_q - NW'(1);
  assign addr_full = (cnt_q == '0) ? n_m1 : (cnt_q - NW'(1));
  assign rd_addr_o = addr_full[AW-1:0];

  always_comb begin
    cmd_o.vtx_wr  = accept & (op_i == OP_LOAD) & idx_ok;
    cmd_o.start   = accept & (op_i == OP_QUERY);
    cmd_o.rd_en   = (state_q == S_RUN);
    cmd_o.edge_ok = (state_q == S_RUN) & (cnt_q != '0);
    cmd_o.last    = (state_q == S_RUN) & (cnt_q == n_q);
  end

  assign out_free = ~out_valid_q | ~out_stall_i;

  // Sequencer, count register and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      n_q          <= NW'(MIN_VERTICES);
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_inside_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        n_q <= n_d;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (cmd_o.start) begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          cnt_q <= cnt_q + NW'(1);
          if (cnt_q == n_q) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (status_i.done) begin
            state_q <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_inside_q <= status_i.in_poly;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_inside_q;

endmodule

// ===== hdl/point_in_polygon_test.sv =====
// Even-odd point-in-polygon test over a stored polygon of n vertices.
// A load item writes its vertex at once when it is taken.
// A query reads n + 1 vertices through one store read port, one per cycle,
// and its result is registered once the final edge has left the pipeline and the output register is free.
// A new item can be taken in the cycle after the query's result is registered.
// Reset is asynchronous and active low; the vertex count resets to 3.
module point_in_polygon_test #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned COORD_BITS   = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [pip_pkg::IDX_W-1:0]     vertex_index_i,
  input  logic signed [COORD_BITS-1:0]  coord_x_i,
  input  logic signed [COORD_BITS-1:0]  coord_y_i,
  input  logic                          cfg_we_i,
  input  logic [pip_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          inside_res_o
);
  import pip_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [AW-1:0] rd_addr, wr_addr;

  // Sequencer and output register.
  pip_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW),
    .NW           (NW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .vertex_index_i (vertex_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inside_res_o   (inside_res_o),
    .cmd_o          (cmd),
    .rd_addr_o      (rd_addr),
    .wr_addr_o      (wr_addr),
    .status_i       (status)
  );

  // Vertex store and edge pipeline.
  pip_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .AW           (AW)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .status_o  (status)
  );

endmodule

// ===== hdl/pip_checker.sv =====
module pip_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic op_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic inside_res_o
);
  import pip_pkg::*;

  logic query_taken;

  assign query_taken = in_valid_i & ~in_stall_o & (op_i == OP_QUERY);

  // A stalled result stays and keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(inside_res_o))
    else $error("stalled result changed");

  // A query holds off further items while it walks the polygon.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_taken |=> in_stall_o)
    else $error("item taken during a query");

  // No result can come out in the cycle right after a query is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_taken |=> !$rose(out_valid_o))
    else $error("result too early");

  // A new result only appears at the end of a query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a query");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);
